### design/deq_pkg.sv
// Package for the double-ended queue block: request codes, status codes,
// field widths and the control words for the storage chain and for its cells.
// No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Move for one cell. load wins over the shifts.
  typedef struct packed {
    logic shift_up;    // take the neighbor at the next lower index
    logic shift_down;  // take the neighbor at the next higher index
    logic load;        // take the pushed value
  } cell_ctl_t;

  // Move for a whole chain; the load index travels beside it.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load;
  } chain_ctl_t;

endpackage

### design/deque_buffer.sv
// Top level of the double-ended queue of signed 32-bit values.
// Depends on deq_pkg and deq_chain (which uses deq_cell).
`timescale 1ns / 1ps

// How to use this block:
// A request is taken at a rising edge where start is high and busy is low.
// busy is always low, so a new request may be issued every clock cycle.
// cmd selects push front, push back, pop front, pop back, peek front,
// peek back or clear; value_in is the value for a push.
// Each request produces exactly one response, presented on read_value,
// status, occupancy and is_empty for one cycle with done high, in the cycle
// after the request was taken. The receiver cannot stall the response, so
// none is ever held back. Throughput is one request per cycle; the response
// is held in the output register.
// Storage is two identical chains of DEPTH cells holding the same sequence.
// The front chain keeps the front entry in its lowest cell; the back chain
// keeps the back entry in its highest cell. A push at one end shifts that
// end's chain and loads the other chain at the cell given by the count, so
// both ends can always be peeked from a fixed cell.
// A push on a full queue reports a full error; a pop or peek on an empty
// queue reports an empty error. Neither changes the contents.
// Synchronous reset empties the queue and clears done. The cell contents
// are not reset; they are only read after having been written.
module deque_buffer #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [deq_pkg::CMD_W-1:0]           cmd,
  input  logic signed [deq_pkg::DATA_W-1:0]   value_in,
  output logic                                done,
  output logic signed [deq_pkg::DATA_W-1:0]   read_value,
  output logic [deq_pkg::STATUS_W-1:0]        status,
  output logic [deq_pkg::OCC_W-1:0]           occupancy,
  output logic                                is_empty
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [DATA_W-1:0] rd_next;
  logic [STATUS_W-1:0] st_next;
  logic              q_empty;
  logic              q_full;

  chain_ctl_t        front_ctl;
  chain_ctl_t        back_ctl;
  logic [IDX_W-1:0]  front_load_idx;
  logic [IDX_W-1:0]  back_load_idx;
  logic [DATA_W-1:0] front_head;
  logic [DATA_W-1:0] front_tail;
  logic [DATA_W-1:0] back_head;
  logic [DATA_W-1:0] back_tail;

  // No request ever holds the block busy.
  assign busy = 1'b0;

  assign q_empty = (count == '0);
  assign q_full  = (count == CNT_W'(DEPTH));

  // A push at the back lands in the front chain just past its last entry;
  // a push at the front lands in the back chain just before its first one.
  assign front_load_idx = count[IDX_W-1:0];
  assign back_load_idx  = IDX_W'(DEPTH - 1) - count[IDX_W-1:0];

  always_comb begin
    count_next = count;
    rd_next    = '0;
    st_next    = ST_OK;
    front_ctl  = '0;
    back_ctl   = '0;
    if (start) begin
      unique case (cmd)
        CMD_PUSH_FRONT: begin
          if (q_full) begin
            st_next = ST_FULL;
          end else begin
            front_ctl.shift_up = 1'b1;
            back_ctl.load      = 1'b1;
            count_next         = count + 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (q_full) begin
            st_next = ST_FULL;
          end else begin
            back_ctl.shift_down = 1'b1;
            front_ctl.load      = 1'b1;
            count_next          = count + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (q_empty) begin
            st_next = ST_EMPTY;
          end else begin
            front_ctl.shift_down = 1'b1;
            count_next           = count - 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (q_empty) begin
            st_next = ST_EMPTY;
          end else begin
            back_ctl.shift_up = 1'b1;
            count_next        = count - 1'b1;
          end
        end
        CMD_PEEK_FRONT: begin
          if (q_empty) begin
            st_next = ST_EMPTY;
          end else begin
            rd_next = front_head;
          end
        end
        CMD_PEEK_BACK: begin
          if (q_empty) begin
            st_next = ST_EMPTY;
          end else begin
            rd_next = back_tail;
          end
        end
        CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  deq_chain #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_front_chain (
    .clk      (clk),
    .ctl      (front_ctl),
    .load_idx (front_load_idx),
    .data_in  (value_in),
    .low_end  (front_head),
    .high_end (front_tail)
  );

  deq_chain #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_back_chain (
    .clk      (clk),
    .ctl      (back_ctl),
    .load_idx (back_load_idx),
    .data_in  (value_in),
    .low_end  (back_head),
    .high_end (back_tail)
  );

  // The far ends of the chains carry no queue information of their own;
  // they are folded in only so that every chain output is consumed.
  logic unused_ends;
  assign unused_ends = ^{front_tail, back_head};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= start;
    end
  end

  // Response payload registers; qualified by done.
  always_ff @(posedge clk) begin
    read_value <= rd_next;
    status     <= st_next;
    occupancy  <= OCC_W'(count_next);
    is_empty   <= (count_next == '0) ^ (unused_ends & 1'b0);
  end

endmodule

### design/deq_cell.sv
// One storage cell of the queue chain: a data register that holds, loads
// the pushed value, or copies one of its two neighbors. Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_cell (
  input  logic                       clk,
  input  deq_pkg::cell_ctl_t         ctl,
  input  logic [deq_pkg::DATA_W-1:0] from_lo,
  input  logic [deq_pkg::DATA_W-1:0] from_hi,
  input  logic [deq_pkg::DATA_W-1:0] load_data,
  output logic [deq_pkg::DATA_W-1:0] q
);
  import deq_pkg::*;

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      q <= load_data;
    end else if (ctl.shift_up) begin
      q <= from_lo;
    end else if (ctl.shift_down) begin
      q <= from_hi;
    end
  end

endmodule

### design/deq_chain.sv
// A row of DEPTH storage cells that shift toward either end or load one
// cell at a given index. Both end cells are read out. Depends on deq_pkg, deq_cell.
`timescale 1ns / 1ps

module deq_chain #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  deq_pkg::chain_ctl_t        ctl,
  input  logic [IDX_W-1:0]           load_idx,
  input  logic [deq_pkg::DATA_W-1:0] data_in,
  output logic [deq_pkg::DATA_W-1:0] low_end,
  output logic [deq_pkg::DATA_W-1:0] high_end
);
  import deq_pkg::*;

  logic [DATA_W-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t         cctl;
    logic [DATA_W-1:0] lo_src;
    logic [DATA_W-1:0] hi_src;

    assign cctl.shift_up   = ctl.shift_up;
    assign cctl.shift_down = ctl.shift_down;
    assign cctl.load       = ctl.load && (load_idx == IDX_W'(i));

    if (i == 0) begin : g_lo_edge
      assign lo_src = data_in;
    end else begin : g_lo_mid
      assign lo_src = q[i-1];
    end

    if (i == DEPTH-1) begin : g_hi_edge
      assign hi_src = data_in;
    end else begin : g_hi_mid
      assign hi_src = q[i+1];
    end

    deq_cell u_cell (
      .clk       (clk),
      .ctl       (cctl),
      .from_lo   (lo_src),
      .from_hi   (hi_src),
      .load_data (data_in),
      .q         (q[i])
    );
  end

  assign low_end  = q[0];
  assign high_end = q[DEPTH-1];

endmodule
